### sv/segment_box_clipper_top_macros.svh
// assertion macros for the segment box clipper checker
// needs a clock named i_clk and an active low reset named i_rst_n in scope
`ifndef SEGMENT_BOX_CLIPPER_TOP_MACROS_SVH
`define SEGMENT_BOX_CLIPPER_TOP_MACROS_SVH

// same-cycle implication
`define SBC_ASSERT_NOW(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error(msg);

// next-cycle implication
`define SBC_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

### sv/sbc_pkg.sv
// shared types and constants for the segment box clipper
// no dependencies
package sbc_pkg;

    localparam int SBC_COORD_W   = 32;
    localparam int SBC_T_FRAC    = 16;
    localparam int SBC_T_W       = SBC_T_FRAC + 1;
    localparam int SBC_T_HALF    = 1 << (SBC_T_FRAC - 1);
    localparam logic [SBC_T_W-1:0] SBC_T_ONE = SBC_T_W'(1) << SBC_T_FRAC;
    localparam int SBC_DIV_STG   = 8;
    localparam int SBC_DIV_LAT   = SBC_DIV_STG + 1;
    localparam int SBC_NUM_AXES  = 3;
    localparam int SBC_NUM_FACES = 6;
    localparam int SBC_CFG_IDX_W = 3;

    localparam logic [SBC_CFG_IDX_W-1:0] SBC_REG_X_MIN = 3'd0;
    localparam logic [SBC_CFG_IDX_W-1:0] SBC_REG_X_MAX = 3'd1;
    localparam logic [SBC_CFG_IDX_W-1:0] SBC_REG_Y_MIN = 3'd2;
    localparam logic [SBC_CFG_IDX_W-1:0] SBC_REG_Y_MAX = 3'd3;
    localparam logic [SBC_CFG_IDX_W-1:0] SBC_REG_Z_MIN = 3'd4;
    localparam logic [SBC_CFG_IDX_W-1:0] SBC_REG_Z_MAX = 3'd5;

    typedef struct packed {
        logic               valid;
        logic               hit;
        logic [SBC_T_W-1:0] tmin;
        logic [SBC_T_W-1:0] tmax;
    } t_ctl;

endpackage

### sv/sbc_div.sv
// pipelined restoring divider giving the crossing parameter of one face
// depends on sbc_pkg
module sbc_div #(
    parameter int COORD_WIDTH = sbc_pkg::SBC_COORD_W
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [COORD_WIDTH:0]            i_num,
    input  logic [COORD_WIDTH:0]            i_den,
    output logic [sbc_pkg::SBC_T_W-1:0]     o_t
);
    import sbc_pkg::*;

    localparam int NW    = COORD_WIDTH + 1;
    localparam int STEPS = SBC_T_FRAC / SBC_DIV_STG;

    logic [NW-1:0]         r_r    [SBC_DIV_STG+1];
    logic [NW-1:0]         r_d    [SBC_DIV_STG+1];
    logic [SBC_T_FRAC-1:0] r_q    [SBC_DIV_STG+1];
    logic                  r_zero [SBC_DIV_STG+1];
    logic                  r_one  [SBC_DIV_STG+1];

    logic          w_nneg, w_dneg;
    logic [NW-1:0] w_nm, w_dm;

    always_comb begin
        w_nneg = i_num[NW-1];
        w_dneg = i_den[NW-1];
        w_nm   = w_nneg ? (~i_num + 1'b1) : i_num;
        w_dm   = w_dneg ? (~i_den + 1'b1) : i_den;
    end

    // magnitudes and the cases that need no division
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r[0]    <= w_nm;
            r_d[0]    <= w_dm;
            r_q[0]    <= '0;
            r_zero[0] <= (i_den == '0) || (i_num == '0) || (w_nneg != w_dneg);
            r_one[0]  <= (w_nm >= w_dm);
        end
    end

    for (genvar g = 0; g < SBC_DIV_STG; g++) begin : g_stg
        logic [NW-1:0]         n_r;
        logic [SBC_T_FRAC-1:0] n_q;
        logic [NW:0]           w_sh;

        always_comb begin
            n_r  = r_r[g];
            n_q  = r_q[g];
            w_sh = '0;
            for (int k = 0; k < STEPS; k++) begin
                w_sh = {n_r, 1'b0};
                n_q  = {n_q[SBC_T_FRAC-2:0], 1'b0};
                if (w_sh >= {1'b0, r_d[g]}) begin
                    w_sh   = w_sh - {1'b0, r_d[g]};
                    n_q[0] = 1'b1;
                end
                n_r = w_sh[NW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[g+1]    <= n_r;
                r_d[g+1]    <= r_d[g];
                r_q[g+1]    <= n_q;
                r_zero[g+1] <= r_zero[g];
                r_one[g+1]  <= r_one[g];
            end
        end
    end

    assign o_t = r_zero[SBC_DIV_STG] ? '0 :
                 r_one[SBC_DIV_STG]  ? SBC_T_ONE :
                                       {1'b0, r_q[SBC_DIV_STG]};

endmodule

### sv/sbc_face.sv
// one box face: side test and clamp, scaling multiply, end point update
// depends on sbc_pkg
module sbc_face #(
    parameter int COORD_WIDTH = sbc_pkg::SBC_COORD_W,
    parameter int FACE        = 0
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  logic [COORD_WIDTH-1:0]                     i_bound,
    input  sbc_pkg::t_ctl                              i_ctl,
    input  logic [2:0][COORD_WIDTH-1:0]                i_st,
    input  logic [2:0]                                 i_dneg,
    input  logic [2:0][COORD_WIDTH:0]                  i_dmag,
    input  logic [5:0][sbc_pkg::SBC_T_W-1:0]           i_tdiv,
    input  logic [2:0][COORD_WIDTH-1:0]                i_cs,
    input  logic [2:0][COORD_WIDTH-1:0]                i_ce,
    output sbc_pkg::t_ctl                              o_ctl,
    output logic [2:0][COORD_WIDTH-1:0]                o_st,
    output logic [2:0]                                 o_dneg,
    output logic [2:0][COORD_WIDTH:0]                  o_dmag,
    output logic [5:0][sbc_pkg::SBC_T_W-1:0]           o_tdiv,
    output logic [2:0][COORD_WIDTH-1:0]                o_cs,
    output logic [2:0][COORD_WIDTH-1:0]                o_ce
);
    import sbc_pkg::*;

    localparam int AX     = FACE / 2;
    localparam int IS_MAX = FACE % 2;
    localparam int PW     = COORD_WIDTH + 1 + SBC_T_W;

    // side test and clamp
    logic                           w_in_s, w_in_e, w_cross;
    logic [SBC_T_W-1:0]             w_t;
    t_ctl                           n_a_ctl;
    logic                           n_a_mvs, n_a_mve;
    t_ctl                           r_a_ctl;
    logic                           r_a_mvs, r_a_mve;
    logic [SBC_T_W-1:0]             r_a_t;
    logic [2:0][COORD_WIDTH-1:0]    r_a_st, r_a_cs, r_a_ce;
    logic [2:0]                     r_a_dneg;
    logic [2:0][COORD_WIDTH:0]      r_a_dmag;
    logic [5:0][SBC_T_W-1:0]        r_a_tdiv;

    always_comb begin
        if (IS_MAX != 0) begin
            w_in_s = $signed(i_cs[AX]) <= $signed(i_bound);
            w_in_e = $signed(i_ce[AX]) <= $signed(i_bound);
        end else begin
            w_in_s = $signed(i_cs[AX]) >= $signed(i_bound);
            w_in_e = $signed(i_ce[AX]) >= $signed(i_bound);
        end
        w_cross = w_in_s ^ w_in_e;
        w_t = i_tdiv[FACE];
        if (w_t < i_ctl.tmin) begin
            w_t = i_ctl.tmin;
        end
        if (w_t > i_ctl.tmax) begin
            w_t = i_ctl.tmax;
        end
        n_a_ctl = i_ctl;
        n_a_mvs = 1'b0;
        n_a_mve = 1'b0;
        if (i_ctl.hit) begin
            if (!w_in_s && !w_in_e) begin
                n_a_ctl.hit = 1'b0;
            end else if (w_cross) begin
                if (w_in_s) begin
                    n_a_ctl.tmax = w_t;
                    n_a_mve      = 1'b1;
                end else begin
                    n_a_ctl.tmin = w_t;
                    n_a_mvs      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else if (i_en) begin
            r_a_ctl <= n_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mvs  <= n_a_mvs;
            r_a_mve  <= n_a_mve;
            r_a_t    <= w_t;
            r_a_st   <= i_st;
            r_a_cs   <= i_cs;
            r_a_ce   <= i_ce;
            r_a_dneg <= i_dneg;
            r_a_dmag <= i_dmag;
            r_a_tdiv <= i_tdiv;
        end
    end

    // |d| * t for each axis
    t_ctl                           r_b_ctl;
    logic                           r_b_mvs, r_b_mve;
    logic [2:0][COORD_WIDTH-1:0]    r_b_st, r_b_cs, r_b_ce;
    logic [2:0]                     r_b_dneg;
    logic [2:0][COORD_WIDTH:0]      r_b_dmag;
    logic [5:0][SBC_T_W-1:0]        r_b_tdiv;
    logic [2:0][PW-1:0]             r_b_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else if (i_en) begin
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_mvs  <= r_a_mvs;
            r_b_mve  <= r_a_mve;
            r_b_st   <= r_a_st;
            r_b_cs   <= r_a_cs;
            r_b_ce   <= r_a_ce;
            r_b_dneg <= r_a_dneg;
            r_b_dmag <= r_a_dmag;
            r_b_tdiv <= r_a_tdiv;
            for (int a = 0; a < 3; a++) begin
                r_b_prod[a] <= PW'(r_a_dmag[a]) * PW'(r_a_t);
            end
        end
    end

    // round to nearest, apply direction sign, move the chosen end
    logic [2:0][COORD_WIDTH-1:0]    w_new;
    logic [PW-1:0]                  w_rnd;
    logic [COORD_WIDTH:0]           w_p, w_stx, w_sum;
    t_ctl                           r_c_ctl;
    logic [2:0][COORD_WIDTH-1:0]    r_c_st, r_c_cs, r_c_ce;
    logic [2:0]                     r_c_dneg;
    logic [2:0][COORD_WIDTH:0]      r_c_dmag;
    logic [5:0][SBC_T_W-1:0]        r_c_tdiv;

    always_comb begin
        w_rnd = '0;
        w_p   = '0;
        w_stx = '0;
        w_sum = '0;
        for (int a = 0; a < 3; a++) begin
            w_rnd    = r_b_prod[a] + PW'(SBC_T_HALF);
            w_p      = w_rnd[SBC_T_FRAC +: COORD_WIDTH+1];
            w_stx    = {r_b_st[a][COORD_WIDTH-1], r_b_st[a]};
            w_sum    = r_b_dneg[a] ? (w_stx - w_p) : (w_stx + w_p);
            w_new[a] = w_sum[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_ctl <= '0;
        end else if (i_en) begin
            r_c_ctl <= r_b_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_st   <= r_b_st;
            r_c_dneg <= r_b_dneg;
            r_c_dmag <= r_b_dmag;
            r_c_tdiv <= r_b_tdiv;
            r_c_cs   <= r_b_mvs ? w_new : r_b_cs;
            r_c_ce   <= r_b_mve ? w_new : r_b_ce;
        end
    end

    assign o_ctl  = r_c_ctl;
    assign o_st   = r_c_st;
    assign o_dneg = r_c_dneg;
    assign o_dmag = r_c_dmag;
    assign o_tdiv = r_c_tdiv;
    assign o_cs   = r_c_cs;
    assign o_ce   = r_c_ce;

endmodule

### sv/segment_box_clipper_top.sv
// segment box clipper
// throughput one item per cycle while no result is held; a held result freezes the whole pipeline in place
// the 16-step crossing divisions (8 stages) and six 3-stage face units set the depth
// synchronous active low reset empties the pipeline and clears the box to zero
// depends on sbc_pkg, sbc_div, sbc_face
module segment_box_clipper_top #(
    parameter int COORD_WIDTH = sbc_pkg::SBC_COORD_W
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [sbc_pkg::SBC_CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]              i_cfg_data,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [COORD_WIDTH-1:0]       i_start_x,
    input  logic signed [COORD_WIDTH-1:0]       i_start_y,
    input  logic signed [COORD_WIDTH-1:0]       i_start_z,
    input  logic signed [COORD_WIDTH-1:0]       i_stop_x,
    input  logic signed [COORD_WIDTH-1:0]       i_stop_y,
    input  logic signed [COORD_WIDTH-1:0]       i_stop_z,
    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_hit,
    output logic signed [COORD_WIDTH-1:0]       o_clip_start_x,
    output logic signed [COORD_WIDTH-1:0]       o_clip_start_y,
    output logic signed [COORD_WIDTH-1:0]       o_clip_start_z,
    output logic signed [COORD_WIDTH-1:0]       o_clip_stop_x,
    output logic signed [COORD_WIDTH-1:0]       o_clip_stop_y,
    output logic signed [COORD_WIDTH-1:0]       o_clip_stop_z,
    output logic [sbc_pkg::SBC_T_W-1:0]         o_param_min,
    output logic [sbc_pkg::SBC_T_W-1:0]         o_param_max
);
    import sbc_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int DL = SBC_DIV_LAT;

    // one enable for every stage: the pipeline moves unless the output item is held
    logic w_en;
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // box registers, one per face in face order
    logic [CW-1:0] r_box [SBC_NUM_FACES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < SBC_NUM_FACES; f++) begin
                r_box[f] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                SBC_REG_X_MIN: r_box[0] <= i_cfg_data;
                SBC_REG_X_MAX: r_box[1] <= i_cfg_data;
                SBC_REG_Y_MIN: r_box[2] <= i_cfg_data;
                SBC_REG_Y_MAX: r_box[3] <= i_cfg_data;
                SBC_REG_Z_MIN: r_box[4] <= i_cfg_data;
                SBC_REG_Z_MAX: r_box[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // entry stage: direction d = stop - start, and the division numerators
    // bound - start for every face, all one bit wider than a coordinate
    logic [2:0][CW-1:0]   w_in_st, w_in_sp;
    logic                 r_e_valid;
    logic [2:0][CW-1:0]   r_e_st;
    logic [2:0][CW:0]     r_e_dir;
    logic [5:0][CW:0]     r_e_num;

    assign w_in_st = {i_start_z, i_start_y, i_start_x};
    assign w_in_sp = {i_stop_z, i_stop_y, i_stop_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_en) begin
            r_e_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_st <= w_in_st;
            for (int a = 0; a < 3; a++) begin
                r_e_dir[a] <= {w_in_sp[a][CW-1], w_in_sp[a]} - {w_in_st[a][CW-1], w_in_st[a]};
            end
            for (int f = 0; f < SBC_NUM_FACES; f++) begin
                r_e_num[f] <= {r_box[f][CW-1], r_box[f]}
                            - {w_in_st[f/2][CW-1], w_in_st[f/2]};
            end
        end
    end

    // crossing parameters of all six faces, from the original segment only
    logic [5:0][SBC_T_W-1:0] w_tdiv;

    for (genvar f = 0; f < SBC_NUM_FACES; f++) begin : g_div
        sbc_div #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_e_num[f]),
            .i_den (r_e_dir[f/2]),
            .o_t   (w_tdiv[f])
        );
    end

    // delay line alongside the dividers; the first stage splits d into sign
    // and magnitude and rebuilds the stop point
    logic                 r_d_valid [DL];
    logic [2:0][CW-1:0]   r_d_st    [DL];
    logic [2:0][CW-1:0]   r_d_sp    [DL];
    logic [2:0]           r_d_dneg  [DL];
    logic [2:0][CW:0]     r_d_dmag  [DL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DL; k++) begin
                r_d_valid[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_d_valid[0] <= r_e_valid;
            for (int k = 1; k < DL; k++) begin
                r_d_valid[k] <= r_d_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_st[0] <= r_e_st;
            for (int a = 0; a < 3; a++) begin
                r_d_sp[0][a]   <= r_e_st[a] + r_e_dir[a][CW-1:0];
                r_d_dneg[0][a] <= r_e_dir[a][CW];
                r_d_dmag[0][a] <= r_e_dir[a][CW] ? (~r_e_dir[a] + 1'b1) : r_e_dir[a];
            end
            for (int k = 1; k < DL; k++) begin
                r_d_st[k]   <= r_d_st[k-1];
                r_d_sp[k]   <= r_d_sp[k-1];
                r_d_dneg[k] <= r_d_dneg[k-1];
                r_d_dmag[k] <= r_d_dmag[k-1];
            end
        end
    end

    // six face units in the fixed order x min, x max, y min, y max, z min, z max
    t_ctl                     w_f_ctl  [SBC_NUM_FACES+1];
    logic [2:0][CW-1:0]       w_f_st   [SBC_NUM_FACES+1];
    logic [2:0]               w_f_dneg [SBC_NUM_FACES+1];
    logic [2:0][CW:0]         w_f_dmag [SBC_NUM_FACES+1];
    logic [5:0][SBC_T_W-1:0]  w_f_tdiv [SBC_NUM_FACES+1];
    logic [2:0][CW-1:0]       w_f_cs   [SBC_NUM_FACES+1];
    logic [2:0][CW-1:0]       w_f_ce   [SBC_NUM_FACES+1];

    // fresh item: whole segment, t range 0 to 1
    always_comb begin
        w_f_ctl[0].valid = r_d_valid[DL-1];
        w_f_ctl[0].hit   = 1'b1;
        w_f_ctl[0].tmin  = '0;
        w_f_ctl[0].tmax  = SBC_T_ONE;
    end
    assign w_f_st[0]   = r_d_st[DL-1];
    assign w_f_dneg[0] = r_d_dneg[DL-1];
    assign w_f_dmag[0] = r_d_dmag[DL-1];
    assign w_f_tdiv[0] = w_tdiv;
    assign w_f_cs[0]   = r_d_st[DL-1];
    assign w_f_ce[0]   = r_d_sp[DL-1];

    for (genvar f = 0; f < SBC_NUM_FACES; f++) begin : g_face
        sbc_face #(
            .COORD_WIDTH (COORD_WIDTH),
            .FACE        (f)
        ) u_face (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_bound (r_box[f]),
            .i_ctl   (w_f_ctl[f]),
            .i_st    (w_f_st[f]),
            .i_dneg  (w_f_dneg[f]),
            .i_dmag  (w_f_dmag[f]),
            .i_tdiv  (w_f_tdiv[f]),
            .i_cs    (w_f_cs[f]),
            .i_ce    (w_f_ce[f]),
            .o_ctl   (w_f_ctl[f+1]),
            .o_st    (w_f_st[f+1]),
            .o_dneg  (w_f_dneg[f+1]),
            .o_dmag  (w_f_dmag[f+1]),
            .o_tdiv  (w_f_tdiv[f+1]),
            .o_cs    (w_f_cs[f+1]),
            .o_ce    (w_f_ce[f+1])
        );
    end

    // output register; a missed segment reports every field as zero
    t_ctl                 w_last;
    logic                 r_out_valid;
    logic                 r_hit;
    logic [2:0][CW-1:0]   r_cs, r_ce;
    logic [SBC_T_W-1:0]   r_tmin, r_tmax;

    assign w_last = w_f_ctl[SBC_NUM_FACES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit  <= w_last.hit;
            r_cs   <= w_last.hit ? w_f_cs[SBC_NUM_FACES] : '0;
            r_ce   <= w_last.hit ? w_f_ce[SBC_NUM_FACES] : '0;
            r_tmin <= w_last.hit ? w_last.tmin : '0;
            r_tmax <= w_last.hit ? w_last.tmax : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_hit;
    assign o_clip_start_x = r_cs[0];
    assign o_clip_start_y = r_cs[1];
    assign o_clip_start_z = r_cs[2];
    assign o_clip_stop_x  = r_ce[0];
    assign o_clip_stop_y  = r_ce[1];
    assign o_clip_stop_z  = r_ce[2];
    assign o_param_min    = r_tmin;
    assign o_param_max    = r_tmax;

endmodule

### sv/sbc_checker.sv
// port-level checks on the segment box clipper, bound to the top level
// depends on sbc_pkg and segment_box_clipper_top_macros.svh
`include "segment_box_clipper_top_macros.svh"

module sbc_port_checks #(
    parameter int COORD_WIDTH = sbc_pkg::SBC_COORD_W
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic                               o_hit,
    input logic [COORD_WIDTH-1:0]             o_clip_start_x,
    input logic [COORD_WIDTH-1:0]             o_clip_start_y,
    input logic [COORD_WIDTH-1:0]             o_clip_start_z,
    input logic [COORD_WIDTH-1:0]             o_clip_stop_x,
    input logic [COORD_WIDTH-1:0]             o_clip_stop_y,
    input logic [COORD_WIDTH-1:0]             o_clip_stop_z,
    input logic [sbc_pkg::SBC_T_W-1:0]        o_param_min,
    input logic [sbc_pkg::SBC_T_W-1:0]        o_param_max
);
    import sbc_pkg::*;

    localparam int FW = 1 + 6 * COORD_WIDTH + 2 * SBC_T_W;

    logic          w_fields_zero;
    logic [FW-1:0] w_fields;

    assign w_fields_zero = (o_clip_start_x == '0) && (o_clip_start_y == '0)
                        && (o_clip_start_z == '0) && (o_clip_stop_x == '0)
                        && (o_clip_stop_y == '0) && (o_clip_stop_z == '0)
                        && (o_param_min == '0) && (o_param_max == '0);

    assign w_fields = {o_hit, o_clip_start_x, o_clip_start_y, o_clip_start_z,
                       o_clip_stop_x, o_clip_stop_y, o_clip_stop_z,
                       o_param_min, o_param_max};

    // a miss carries nothing but zeros
    `SBC_ASSERT_NOW(a_miss_zero, o_out_valid && !o_hit, w_fields_zero, "miss item with nonzero fields")

    // a hit keeps its t range ordered and within one
    `SBC_ASSERT_NOW(a_t_order, o_out_valid && o_hit, (o_param_min <= o_param_max) && (o_param_max <= SBC_T_ONE), "t range out of order")

    // input side is never held back by an empty or draining output register
    `SBC_ASSERT_NOW(a_ready_free, !o_out_valid || i_out_ready, o_in_ready, "input stalled without cause")

    // a held result stays put
    `SBC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(w_fields), "held item changed")

endmodule

bind segment_box_clipper_top sbc_port_checks #(.COORD_WIDTH(COORD_WIDTH)) u_sbc_checker (.*);

### bench/sbc_checker.sv
// checker for the segment box clipper: watches both channels, predicts each result item
// from the box registers and compares it field by field; depends on sbc_pkg
`timescale 1ns / 100ps
module sbc_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sbc_pkg::SBC_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                       i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic signed [31:0]                i_sx, i_sy, i_sz, i_ex, i_ey, i_ez,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic                              i_hit,
    input  logic signed [31:0]                i_csx, i_csy, i_csz, i_cex, i_cey, i_cez,
    input  logic [16:0]                       i_pmin, i_pmax,
    output int                                o_fail_count,
    output int                                o_pending
);
    import sbc_pkg::*;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] sx, sy, sz, ex, ey, ez;
        logic [16:0]        pmin, pmax;
    } t_clip;

    logic signed [31:0] box [6];
    t_clip clip_q [$];

    assign o_pending = clip_q.size();

    function automatic longint unsigned crossing(longint num, longint den);
        longint unsigned n, d, r, q;
        q = 0;
        if (den == 0 || num == 0 || ((num < 0) != (den < 0))) return 0;
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        if (n >= d) return 65536;
        r = n;
        for (int i = 0; i < 16; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic longint move_along(longint s, longint dir, longint unsigned t);
        longint unsigned m, p;
        m = dir < 0 ? -dir : dir;
        p = (m >> 16) * t + (((m & 65535) * t + 32768) >> 16);
        return dir < 0 ? s - longint'(p) : s + longint'(p);
    endfunction

    function automatic t_clip clip_segment(longint s0, s1, s2, e0, e1, e2);
        longint st [3], dir [3], cs [3], ce [3];
        longint unsigned tmin, tmax, t;
        longint bound, d1, d2;
        int ax;
        t_clip r;
        r = '0;
        tmin = 0;
        tmax = 65536;
        st = '{s0, s1, s2};
        ce = '{e0, e1, e2};
        cs = st;
        for (int a = 0; a < 3; a++) dir[a] = ce[a] - st[a];
        for (int f = 0; f < 6; f++) begin
            ax = f >> 1;
            bound = box[f];
            d1 = cs[ax] - bound;
            d2 = ce[ax] - bound;
            if (f & 1) begin
                d1 = -d1;
                d2 = -d2;
            end
            // both ends outside this face: miss, all fields zero
            if (d1 < 0 && d2 < 0) return '0;
            if (d1 < 0 || d2 < 0) begin
                t = crossing(bound - st[ax], dir[ax]);
                if (t < tmin) t = tmin;
                if (t > tmax) t = tmax;
                if (d1 >= 0) begin
                    tmax = t;
                    for (int a = 0; a < 3; a++) ce[a] = move_along(st[a], dir[a], t);
                end else begin
                    tmin = t;
                    for (int a = 0; a < 3; a++) cs[a] = move_along(st[a], dir[a], t);
                end
            end
        end
        r.hit = 1'b1;
        r.sx = 32'(cs[0]); r.sy = 32'(cs[1]); r.sz = 32'(cs[2]);
        r.ex = 32'(ce[0]); r.ey = 32'(ce[1]); r.ez = 32'(ce[2]);
        r.pmin = 17'(tmin); r.pmax = 17'(tmax);
        return r;
    endfunction

    task automatic cmp(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            o_fail_count++;
        end
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_clip w;
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) box[i] <= '0;
        end else begin
            if (i_cfg_we && i_cfg_idx < SBC_NUM_FACES) box[i_cfg_idx] <= i_cfg_data;
            if (i_in_valid && i_in_ready)
                clip_q = {clip_q, clip_segment(i_sx, i_sy, i_sz, i_ex, i_ey, i_ez)};
            if (i_out_valid && i_out_ready) begin
                if (clip_q.size() == 0) begin
                    $error("result item with no expectation");
                    o_fail_count++;
                end else begin
                    w = clip_q.pop_front();
                    cmp("hit", w.hit, i_hit);
                    cmp("clip_start_x", w.sx, i_csx);
                    cmp("clip_start_y", w.sy, i_csy);
                    cmp("clip_start_z", w.sz, i_csz);
                    cmp("clip_stop_x", w.ex, i_cex);
                    cmp("clip_stop_y", w.ey, i_cey);
                    cmp("clip_stop_z", w.ez, i_cez);
                    cmp("param_min", w.pmin, i_pmin);
                    cmp("param_max", w.pmax, i_pmax);
                end
            end
        end
    end
endmodule

### bench/tb_top.sv
// stimulus and verdict for the segment box clipper: directed and random segments
// over several box settings and idling phases; depends on sbc_pkg, sbc_checker, the block
`timescale 1ns / 100ps
module tb_top;
    import sbc_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [SBC_CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [31:0] i_sx = 0, i_sy = 0, i_sz = 0, i_ex = 0, i_ey = 0, i_ez = 0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic o_hit;
    logic signed [31:0] o_csx, o_csy, o_csz, o_cex, o_cey, o_cez;
    logic [SBC_T_W-1:0] o_pmin, o_pmax;
    int fail_count, pending;

    // idling percentages, changed per phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // long receiver hold-off, counted down in its own process
    int hold_cycles = 0;

    always #6 i_clk = ~i_clk;

    segment_box_clipper_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_start_x(i_sx), .i_start_y(i_sy), .i_start_z(i_sz),
        .i_stop_x(i_ex), .i_stop_y(i_ey), .i_stop_z(i_ez),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_hit(o_hit),
        .o_clip_start_x(o_csx), .o_clip_start_y(o_csy), .o_clip_start_z(o_csz),
        .o_clip_stop_x(o_cex), .o_clip_stop_y(o_cey), .o_clip_stop_z(o_cez),
        .o_param_min(o_pmin), .o_param_max(o_pmax)
    );

    sbc_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_sx(i_sx), .i_sy(i_sy), .i_sz(i_sz), .i_ex(i_ex), .i_ey(i_ey), .i_ez(i_ez),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_hit(o_hit),
        .i_csx(o_csx), .i_csy(o_csy), .i_csz(o_csz),
        .i_cex(o_cex), .i_cey(o_cey), .i_cez(o_cez),
        .i_pmin(o_pmin), .i_pmax(o_pmax),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: random stalls, or held off entirely while the hold counter runs
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one segment offered; valid held until accepted, random gaps before it
    task automatic send_segment(logic [31:0] sx, sy, sz, ex, ey, ez);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sx <= sx; i_sy <= sy; i_sz <= sz;
        i_ex <= ex; i_ey <= ey; i_ez <= ez;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // wait for every result, then let the pipeline drain before touching registers
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_box(logic [31:0] x0, x1, y0, y1, z0, z1);
        logic [31:0] v [6];
        v = '{x0, x1, y0, y1, z0, z1};
        for (int i = 0; i < 6; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= i[SBC_CFG_IDX_W-1:0];
            i_cfg_data <= v[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // coordinates: mostly near the box, some anywhere, some extremes
    function automatic logic [31:0] pick_coord(int lo, int hi);
        case ($urandom_range(9))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            2: return lo;
            3: return hi;
            default: return lo + $signed($urandom_range(hi - lo + 400000)) - 200000;
        endcase
    endfunction

    task automatic random_burst(int count, int lo, int hi);
        logic [31:0] c [6];
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < 6; k++) c[k] = pick_coord(lo, hi);
            // zero-length segments now and then
            if ($urandom_range(19) == 0) c[3:5] = c[0:2];
            send_segment(c[0], c[1], c[2], c[3], c[4], c[5]);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: box -1.0 .. 1.0 on every axis
        set_box(-32'sh10000, 32'sh10000, -32'sh10000, 32'sh10000, -32'sh10000, 32'sh10000);
        send_segment(0, 0, 0, 32'h8000, 32'h8000, 32'h8000);          // fully inside
        send_segment(-32'sh30000, 0, 0, 32'sh30000, 0, 0);            // through both x faces
        send_segment(32'sh30000, 0, 0, -32'sh30000, 0, 0);            // reversed
        send_segment(0, -32'sh30000, 0, 0, 32'sh30000, 0);
        send_segment(0, 0, -32'sh30000, 0, 0, 32'sh30000);
        send_segment(32'sh20000, 0, 0, 32'sh30000, 0, 0);             // miss on x max
        send_segment(0, 0, 0, 0, 0, 0);                               // zero length inside
        send_segment(32'sh20000, 0, 0, 32'sh20000, 0, 0);             // zero length outside
        send_segment(32'sh10000, 0, 0, 32'sh10000, 32'sh5000, 0);     // lying on a face
        send_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);    // full range diagonal
        send_segment(32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000, 32'h7fff_ffff, 0);
        send_segment(-32'sh30000, 32'sh30000, 0, 32'sh30000, 32'sh30000, 0); // miss y
        send_segment(-32'sh30000, -32'sh20000, 0, 32'sh30000, 32'sh40000, 0);
        drain();
        // inverted box: every segment misses
        set_box(32'sh10000, -32'sh10000, 0, 32'sh10000, 0, 32'sh10000);
        send_segment(0, 0, 0, 32'h8000, 32'h8000, 32'h8000);
        send_segment(-32'sh30000, 0, 0, 32'sh30000, 0, 0);
        drain();
        // extreme box covering the whole range
        set_box(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'h8000_0000, 32'h7fff_ffff);
        send_segment(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                     32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        random_burst(200, -32'sh40000000, 32'sh40000000);
        drain();

        // random phases with different idling and boxes
        for (int ph = 0; ph < 4; ph++) begin
            int lo, hi;
            lo = -$signed($urandom_range(32'h0100_0000));
            hi = $urandom_range(32'h0100_0000);
            set_box(lo, hi, lo / 2, hi * 2, lo, hi);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            // long hold-off so the pipeline backs up onto the input
            if (ph == 0) hold_cycles = 200;
            random_burst(330, lo, hi);
            drain();
        end

        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
